// ===== rtl/piecewise_linear_colormap_unit_macros.svh =====
// Assertion macros shared by the colour map RTL.
// Needs a clock named clk and an active-low reset named rst_n in the including scope.
`ifndef PIECEWISE_LINEAR_COLORMAP_UNIT_MACROS_SVH
`define PIECEWISE_LINEAR_COLORMAP_UNIT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PLCM_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PLCM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/plcm_pkg.sv =====
// Shared types and constants for the piecewise-linear colour map.
// No dependencies; used by plcm_regs and piecewise_linear_colormap_unit.
package plcm_pkg;

  localparam int NUM_COLORS           = 7;
  localparam int COUNT_BITS           = 3;
  localparam int COLOR_IDX_BITS       = 3;
  localparam int CFG_IDX_BITS         = 3;
  localparam int CFG_DATA_BITS        = 32;
  localparam int COLOR_BITS           = 32;
  localparam int PAL_CHAN_BITS        = 8;
  localparam int NUM_CHANNELS         = 4;
  localparam int SCALAR_BITS          = 18;
  localparam int FRAC_BITS            = 16;
  localparam int CHANNEL_BITS_DEFAULT = 8;

  localparam logic [CFG_IDX_BITS-1:0] CFG_COLOR_COUNT = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_COLOR_FIRST = 3'd1;

  typedef logic [COLOR_BITS-1:0] color_t;
  typedef color_t [NUM_COLORS-1:0] palette_t;

  typedef struct packed {
    logic [COUNT_BITS-1:0] count;
    palette_t              palette;
  } cfg_state_t;

  localparam logic [COUNT_BITS-1:0] COUNT_RESET = 3'd3;
  localparam palette_t PALETTE_RESET = {
    32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000,
    32'hFF00_00FF, 32'hFFFF_FFFF, 32'h0000_FFFF
  };

endpackage

// ===== rtl/plcm_regs.sv =====
// Configuration register file of the colour map: colour count and seven palette colours.
// Depends on plcm_pkg.
module plcm_regs (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_write_en,
  input  logic [plcm_pkg::CFG_IDX_BITS-1:0]   cfg_index,
  input  logic [plcm_pkg::CFG_DATA_BITS-1:0]  cfg_data,
  output plcm_pkg::cfg_state_t                cfg_state
);

  logic [plcm_pkg::COUNT_BITS-1:0] count_r;
  plcm_pkg::palette_t              palette_r;
  logic [plcm_pkg::CFG_IDX_BITS-1:0] color_sel;

  assign color_sel = cfg_index - plcm_pkg::CFG_COLOR_FIRST;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r   <= plcm_pkg::COUNT_RESET;
      palette_r <= plcm_pkg::PALETTE_RESET;
    end else if (cfg_write_en) begin
      if (cfg_index == plcm_pkg::CFG_COLOR_COUNT) begin
        count_r <= cfg_data[plcm_pkg::COUNT_BITS-1:0];
      end else begin
        palette_r[color_sel] <= cfg_data[plcm_pkg::COLOR_BITS-1:0];
      end
    end
  end

  assign cfg_state.count   = count_r;
  assign cfg_state.palette = palette_r;

endmodule

// ===== rtl/piecewise_linear_colormap_unit.sv =====
// Piecewise-linear colour map: one Q2.16 scalar in, one RGBA colour out per transaction.
// A new transaction is taken every cycle while in_stall is low, and its colour passes through
// the four register stages (classify and scale, palette select, channel multiply, blend and
// output), each of which holds one transaction; a stage refills as soon as the stage after it
// moves on, so a stall on the output only backs up the input once every stage is full.
// Depends on plcm_pkg, plcm_regs and piecewise_linear_colormap_unit_macros.svh.
`include "piecewise_linear_colormap_unit_macros.svh"

module piecewise_linear_colormap_unit #(
  parameter int CHANNEL_BITS = plcm_pkg::CHANNEL_BITS_DEFAULT
) (
  input  logic                                      clk,
  input  logic                                      rst_n,
  input  logic                                      cfg_write_en,
  input  logic [plcm_pkg::CFG_IDX_BITS-1:0]         cfg_index,
  input  logic [plcm_pkg::CFG_DATA_BITS-1:0]        cfg_data,
  input  logic                                      in_valid,
  output logic                                      in_stall,
  input  logic signed [plcm_pkg::SCALAR_BITS-1:0]   in_scalar,
  output logic                                      out_valid,
  input  logic                                      out_stall,
  output logic [CHANNEL_BITS-1:0]                   out_red,
  output logic [CHANNEL_BITS-1:0]                   out_green,
  output logic [CHANNEL_BITS-1:0]                   out_blue,
  output logic [CHANNEL_BITS-1:0]                   out_alpha
);

  localparam int FB        = plcm_pkg::FRAC_BITS;
  localparam int PB        = plcm_pkg::PAL_CHAN_BITS;
  localparam int NCH       = plcm_pkg::NUM_CHANNELS;
  localparam int CIB       = plcm_pkg::COLOR_IDX_BITS;
  localparam int CNB       = plcm_pkg::COUNT_BITS;
  localparam int MAG_BITS  = plcm_pkg::SCALAR_BITS - 1;
  localparam int RAMP_BITS = MAG_BITS + CHANNEL_BITS;
  localparam int POS_BITS  = FB + CIB;
  localparam int DIFF_BITS = PB + 1;
  localparam int PROD_BITS = DIFF_BITS + FB + 1;
  localparam logic [CHANNEL_BITS-1:0] FULL_SCALE = {CHANNEL_BITS{1'b1}};
  localparam logic [CIB-1:0] MAX_LERP_IDX = CIB'(plcm_pkg::NUM_COLORS - 2);

  typedef enum logic [1:0] {
    MODE_RAMP,
    MODE_FLAT,
    MODE_LERP
  } mode_t;

  typedef logic signed [DIFF_BITS-1:0] diff_t;
  typedef logic signed [PROD_BITS-1:0] prod_t;

  plcm_pkg::cfg_state_t cfg;

  plcm_regs u_regs (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_write_en (cfg_write_en),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .cfg_state    (cfg)
  );

  // Stage handshake.
  logic va_r, vb_r, vc_r, vd_r;
  logic rdy_a, rdy_b, rdy_c, rdy_d;

  assign rdy_d    = !vd_r || !out_stall;
  assign rdy_c    = !vc_r || rdy_d;
  assign rdy_b    = !vb_r || rdy_c;
  assign rdy_a    = !va_r || rdy_b;
  assign in_stall = !rdy_a;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
      vc_r <= 1'b0;
      vd_r <= 1'b0;
    end else begin
      if (rdy_a) begin
        va_r <= in_valid;
      end
      if (rdy_b) begin
        vb_r <= va_r;
      end
      if (rdy_c) begin
        vc_r <= vb_r;
      end
      if (rdy_d) begin
        vd_r <= vc_r;
      end
    end
  end

  // Stage A: classify the scalar and form the scaled products.
  logic                 t_pos, t_ge_one;
  logic [CNB-1:0]       cnt_m1;
  mode_t                mode_nxt;
  logic [CIB-1:0]       flat_idx_nxt;
  logic [POS_BITS-1:0]  pos_nxt;
  logic [RAMP_BITS-1:0] ramp_prod_nxt;
  logic [MAG_BITS-1:0]  ramp_mag;

  mode_t                mode_a_r;
  logic [CIB-1:0]       flat_idx_a_r;
  logic [POS_BITS-1:0]  pos_a_r;
  logic [RAMP_BITS-1:0] ramp_prod_a_r;

  assign t_pos    = !in_scalar[plcm_pkg::SCALAR_BITS-1] && (in_scalar != '0);
  assign t_ge_one = !in_scalar[plcm_pkg::SCALAR_BITS-1] && in_scalar[FB];
  assign cnt_m1   = cfg.count - CNB'(1);
  assign ramp_mag = t_pos ? in_scalar[MAG_BITS-1:0] : '0;

  always_comb begin
    flat_idx_nxt = '0;
    if (cfg.count == '0) begin
      mode_nxt = MODE_RAMP;
    end else if (cfg.count == CNB'(1) || !t_pos) begin
      mode_nxt = MODE_FLAT;
    end else if (t_ge_one) begin
      mode_nxt     = MODE_FLAT;
      flat_idx_nxt = CIB'(cnt_m1);
    end else begin
      mode_nxt = MODE_LERP;
    end
    pos_nxt       = POS_BITS'(in_scalar[FB-1:0]) * POS_BITS'(cnt_m1);
    ramp_prod_nxt = RAMP_BITS'(ramp_mag) * RAMP_BITS'(FULL_SCALE);
  end

  always_ff @(posedge clk) begin
    if (rdy_a && in_valid) begin
      mode_a_r      <= mode_nxt;
      flat_idx_a_r  <= flat_idx_nxt;
      pos_a_r       <= pos_nxt;
      ramp_prod_a_r <= ramp_prod_nxt;
    end
  end

  // Stage B: pick the two palette colours and form per-channel differences.
  logic [CIB-1:0]          idx_raw, idx_lim, idx_sel;
  plcm_pkg::color_t        left_col, right_col;
  logic [CHANNEL_BITS:0]   ramp_hi;
  logic [CHANNEL_BITS-1:0] ramp_nxt;
  logic [PB-1:0]           l_nxt [NCH];
  diff_t                   d_nxt [NCH];
  logic [FB-1:0]           frac_nxt;

  logic                    ramp_b_r;
  logic [CHANNEL_BITS-1:0] ramp_val_b_r;
  logic [PB-1:0]           l_b_r [NCH];
  diff_t                   d_b_r [NCH];
  logic [FB-1:0]           frac_b_r;

  assign idx_raw = pos_a_r[POS_BITS-1:FB];
  assign idx_lim = CIB'(cfg.count - CNB'(2));
  assign idx_sel = (idx_raw > idx_lim) ? idx_lim : idx_raw;
  assign ramp_hi = ramp_prod_a_r[FB+CHANNEL_BITS:FB];

  always_comb begin
    if (mode_a_r == MODE_LERP) begin
      left_col  = cfg.palette[idx_sel];
      right_col = cfg.palette[idx_sel + CIB'(1)];
      frac_nxt  = pos_a_r[FB-1:0];
    end else begin
      left_col  = cfg.palette[flat_idx_a_r];
      right_col = left_col;
      frac_nxt  = '0;
    end
    for (int c = 0; c < NCH; c++) begin
      l_nxt[c] = left_col[plcm_pkg::COLOR_BITS-1-PB*c -: PB];
      d_nxt[c] = $signed({1'b0, right_col[plcm_pkg::COLOR_BITS-1-PB*c -: PB]})
               - $signed({1'b0, l_nxt[c]});
    end
    ramp_nxt = (ramp_hi > (CHANNEL_BITS+1)'(FULL_SCALE)) ? FULL_SCALE
                                                        : ramp_hi[CHANNEL_BITS-1:0];
  end

  always_ff @(posedge clk) begin
    if (rdy_b && va_r) begin
      ramp_b_r     <= (mode_a_r == MODE_RAMP);
      ramp_val_b_r <= ramp_nxt;
      l_b_r        <= l_nxt;
      d_b_r        <= d_nxt;
      frac_b_r     <= frac_nxt;
    end
  end

  // Stage C: scale each channel difference by the fraction.
  logic                    ramp_c_r;
  logic [CHANNEL_BITS-1:0] ramp_val_c_r;
  logic [PB-1:0]           l_c_r [NCH];
  prod_t                   prod_c_r [NCH];

  always_ff @(posedge clk) begin
    if (rdy_c && vb_r) begin
      ramp_c_r     <= ramp_b_r;
      ramp_val_c_r <= ramp_val_b_r;
      l_c_r        <= l_b_r;
      for (int c = 0; c < NCH; c++) begin
        prod_c_r[c] <= PROD_BITS'(d_b_r[c]) * $signed({1'b0, frac_b_r});
      end
    end
  end

  // Stage D: blend and drive the output register.
  prod_t                   sum_w [NCH];
  logic [CHANNEL_BITS-1:0] chan_nxt [NCH];
  logic [CHANNEL_BITS-1:0] chan_d_r [NCH];

  always_comb begin
    for (int c = 0; c < NCH; c++) begin
      sum_w[c]    = $signed({2'b00, l_c_r[c], {FB{1'b0}}}) + prod_c_r[c];
      chan_nxt[c] = ramp_c_r ? ramp_val_c_r : CHANNEL_BITS'(sum_w[c][FB+PB-1:FB]);
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_d && vc_r) begin
      chan_d_r <= chan_nxt;
    end
  end

  assign out_valid = vd_r;
  assign out_red   = chan_d_r[0];
  assign out_green = chan_d_r[1];
  assign out_blue  = chan_d_r[2];
  assign out_alpha = chan_d_r[3];

  `PLCM_ASSERT_NEXT(a_accept_fills_a, in_valid && !in_stall, va_r, "accepted transaction lost at stage A")
  `PLCM_ASSERT_NOW(a_stall_only_when_full, in_stall, va_r && vb_r && vc_r && vd_r, "input stalled with a free stage")
  `PLCM_ASSERT_NOW(a_lerp_index_range, va_r && mode_a_r == MODE_LERP, pos_a_r[POS_BITS-1:FB] <= MAX_LERP_IDX, "interpolation index out of range")
  `PLCM_ASSERT_NOW(a_blend_in_range, vc_r && !ramp_c_r, sum_w[0][PROD_BITS-1:FB+PB] == '0 && sum_w[1][PROD_BITS-1:FB+PB] == '0 && sum_w[2][PROD_BITS-1:FB+PB] == '0 && sum_w[3][PROD_BITS-1:FB+PB] == '0, "blend result outside channel range")

endmodule
